>>> design/checked_frame_receiver_core_defines.svh
// Assertion macros shared by the checked frame receiver RTL.
// Needs nothing else; included by the top level only.
`ifndef CHECKED_FRAME_RECEIVER_CORE_DEFINES_SVH
`define CHECKED_FRAME_RECEIVER_CORE_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define CRF_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("checked_frame_receiver_core: property violated");

// Boolean condition that must never be true outside reset.
`define CRF_ASSERT_NEVER(label, clk, rst_n, cond) \
  `CRF_ASSERT(label, clk, rst_n, !(cond))

`endif

>>> design/crf_pkg.sv
// Shared types and constants of the checked frame receiver.
// Used by the parser, payload store, register block and top level.
package crf_pkg;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_LENGTH,
    PH_PAYLOAD,
    PH_CHECK1,
    PH_CHECK2
  } phase_e;

  localparam logic [1:0] MODE_RECV  = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // Start, length and both check bytes.
  localparam logic [7:0] FRAME_OVERHEAD = 8'd4;

  localparam logic [7:0] START_BYTE_RESET = 8'd153;

  // Register index decoded from the APB word address.
  localparam logic REG_START_BYTE = 1'b0;

  typedef struct packed {
    logic       wr_en;
    logic [7:0] wr_addr;
    logic [7:0] wr_data;
    logic       rd_en;
    logic [7:0] rd_addr;
  } store_req_t;

  typedef struct packed {
    logic       rd_sel;
    logic       ready;
    logic [7:0] length;
    logic [7:0] errors;
    logic       done;
    logic       error;
  } step_res_t;

endpackage

>>> design/crf_regs.sv
// APB register block of the checked frame receiver: holds the start byte.
// Depends on crf_pkg for the register index and reset value.
module crf_regs (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  start_byte_o
);

  logic [7:0] start_byte_q;
  logic [7:0] start_byte_d;

  always_comb begin
    start_byte_d = start_byte_q;
    if (psel && penable && pwrite && pready && (paddr[2] == crf_pkg::REG_START_BYTE)) begin
      start_byte_d = pwdata[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= crf_pkg::START_BYTE_RESET;
    end else begin
      start_byte_q <= start_byte_d;
    end
  end

  assign pready       = 1'b1;
  assign prdata       = (paddr[2] == crf_pkg::REG_START_BYTE) ? {24'd0, start_byte_q} : 32'd0;
  assign start_byte_o = start_byte_q;

endmodule

>>> design/crf_store.sv
// Payload memory of the checked frame receiver: one write and one read
// port, read data registered. Depends on crf_pkg for the request struct.
module crf_store #(
  parameter int PAYLOAD_DEPTH = 256
) (
  input  logic                clk_i,
  input  crf_pkg::store_req_t req_i,
  output logic [7:0]          rd_data_o
);

  localparam int AddrW = $clog2(PAYLOAD_DEPTH);

  logic [7:0] mem [PAYLOAD_DEPTH];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr[AddrW-1:0]] <= req_i.wr_data;
    end
  end

  // The read register only moves on a read request, so it holds while the
  // result waits at a stalled output.
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_addr[AddrW-1:0]];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> design/crf_parser.sv
// Frame parser of the checked frame receiver: phase machine, running
// check sums, counters and payload store requests. Depends on crf_pkg.
module crf_parser #(
  parameter int PAYLOAD_DEPTH = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [1:0]          mode_i,
  input  logic [7:0]          data_byte_i,
  input  logic [7:0]          read_index_i,
  input  logic [7:0]          start_byte_i,
  output crf_pkg::store_req_t store_req_o,
  output crf_pkg::step_res_t  res_o
);

  localparam logic [8:0] DepthW = 9'(PAYLOAD_DEPTH);

  crf_pkg::phase_e phase_q, phase_d;
  logic [7:0] length_q, length_d;
  logic [7:0] taken_q, taken_d;
  logic [7:0] sum1_q, sum1_d;
  logic [7:0] sum2_q, sum2_d;
  logic       ready_q, ready_d;
  logic [7:0] errors_q, errors_d;
  logic       done, error;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= crf_pkg::PH_HUNT;
      length_q <= 8'd0;
      taken_q  <= 8'd0;
      sum1_q   <= 8'd0;
      sum2_q   <= 8'd0;
      ready_q  <= 1'b0;
      errors_q <= 8'd0;
    end else begin
      phase_q  <= phase_d;
      length_q <= length_d;
      taken_q  <= taken_d;
      sum1_q   <= sum1_d;
      sum2_q   <= sum2_d;
      ready_q  <= ready_d;
      errors_q <= errors_d;
    end
  end

  always_comb begin
    phase_d  = phase_q;
    length_d = length_q;
    taken_d  = taken_q;
    sum1_d   = sum1_q;
    sum2_d   = sum2_q;
    ready_d  = ready_q;
    errors_d = errors_q;
    done     = 1'b0;
    error    = 1'b0;
    if (accept_i) begin
      case (mode_i)
        crf_pkg::MODE_RECV: begin
          unique case (phase_q)
            crf_pkg::PH_HUNT: begin
              if (data_byte_i == start_byte_i) begin
                phase_d = crf_pkg::PH_LENGTH;
              end
            end
            crf_pkg::PH_LENGTH: begin
              if (ready_q) begin
                // Overrun: a new frame while the last one is unreleased.
                errors_d = errors_q + 8'd2;
                phase_d  = crf_pkg::PH_HUNT;
                error    = 1'b1;
              end else if (data_byte_i < crf_pkg::FRAME_OVERHEAD) begin
                errors_d = errors_q + 8'd1;
                phase_d  = crf_pkg::PH_HUNT;
                error    = 1'b1;
              end else begin
                length_d = data_byte_i - crf_pkg::FRAME_OVERHEAD;
                sum1_d   = data_byte_i;
                sum2_d   = data_byte_i;
                taken_d  = 8'd0;
                phase_d  = (data_byte_i == crf_pkg::FRAME_OVERHEAD) ?
                           crf_pkg::PH_CHECK1 : crf_pkg::PH_PAYLOAD;
              end
            end
            crf_pkg::PH_PAYLOAD: begin
              sum1_d  = sum1_q + data_byte_i;
              sum2_d  = sum2_q + sum1_d;
              taken_d = taken_q + 8'd1;
              if (taken_d == length_q) begin
                phase_d = crf_pkg::PH_CHECK1;
              end
            end
            crf_pkg::PH_CHECK1: begin
              if (data_byte_i != sum1_q) begin
                errors_d = errors_q + 8'd1;
                phase_d  = crf_pkg::PH_HUNT;
                error    = 1'b1;
              end else begin
                phase_d = crf_pkg::PH_CHECK2;
              end
            end
            crf_pkg::PH_CHECK2: begin
              if (data_byte_i != sum2_q) begin
                errors_d = errors_q + 8'd1;
                error    = 1'b1;
              end else begin
                ready_d = 1'b1;
                done    = 1'b1;
              end
              phase_d = crf_pkg::PH_HUNT;
            end
            default: begin
              errors_d = errors_q + 8'd1;
              phase_d  = crf_pkg::PH_HUNT;
              error    = 1'b1;
            end
          endcase
        end
        crf_pkg::MODE_CLEAR: begin
          ready_d = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    store_req_o.wr_en   = accept_i && (mode_i == crf_pkg::MODE_RECV) &&
                          (phase_q == crf_pkg::PH_PAYLOAD) && ({1'b0, taken_q} < DepthW);
    store_req_o.wr_addr = taken_q;
    store_req_o.wr_data = data_byte_i;
    // Reads past the frame length or past the memory answer zero.
    store_req_o.rd_en   = accept_i && (mode_i == crf_pkg::MODE_READ) &&
                          (read_index_i < length_q) && ({1'b0, read_index_i} < DepthW);
    store_req_o.rd_addr = read_index_i;
  end

  always_comb begin
    res_o.rd_sel = store_req_o.rd_en;
    res_o.ready  = ready_d;
    res_o.length = length_d;
    res_o.errors = errors_d;
    res_o.done   = done;
    res_o.error  = error;
  end

endmodule

>>> design/checked_frame_receiver_core.sv
// Checked frame receiver: takes link bytes, parses frames with mod-256 sums,
// stores their payload in memory and lets it be read back by index.
// Channels: a request channel (mode_i, data_byte_i, read_index_i) with
// in_valid_i / in_stall_o, and a result channel with out_valid_o / out_stall_i.
// A request is taken when in_valid_i is high and in_stall_o is low; a result
// is taken when out_valid_o is high and out_stall_i is low.
// Every request gives exactly one result, which appears in the output
// register in the cycle after the request is taken.
// Throughput is one request per cycle while no held result stalls the input:
// the parser state updates per request and the payload memory takes one
// write and one read each cycle, with read data in its own output register.
// When the receiver stalls, the result holds and in_stall_o rises for as long
// as a held result blocks the output register; nothing is dropped.
// Reset clears the parser to hunting for the start byte, clears the ready
// flag, length and error count, and sets the start byte register to 153.
// The payload memory is not cleared; only bytes of received frames are read.
// The start byte is written through the APB port at address 0.
`include "checked_frame_receiver_core_defines.svh"

module checked_frame_receiver_core #(
  parameter int PAYLOAD_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  data_byte_i,
  input  logic [7:0]  read_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  read_data_o,
  output logic        message_ready_o,
  output logic [7:0]  payload_length_o,
  output logic [7:0]  error_count_o,
  output logic        frame_done_o,
  output logic        frame_error_o
);

  logic                accept;
  logic [7:0]          start_byte;
  logic [7:0]          mem_rdata;
  crf_pkg::store_req_t store_req;
  crf_pkg::step_res_t  res;
  crf_pkg::step_res_t  res_q;
  logic                out_valid_q, out_valid_d;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  crf_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .start_byte_o(start_byte)
  );

  crf_parser #(
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .mode_i      (mode_i),
    .data_byte_i (data_byte_i),
    .read_index_i(read_index_i),
    .start_byte_i(start_byte),
    .store_req_o (store_req),
    .res_o       (res)
  );

  crf_store #(
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
  ) u_store (
    .clk_i    (clk_i),
    .req_i    (store_req),
    .rd_data_o(mem_rdata)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign read_data_o      = res_q.rd_sel ? mem_rdata : 8'd0;
  assign message_ready_o  = res_q.ready;
  assign payload_length_o = res_q.length;
  assign error_count_o    = res_q.errors;
  assign frame_done_o     = res_q.done;
  assign frame_error_o    = res_q.error;

  // A byte either completes a frame or aborts one, never both.
  `CRF_ASSERT_NEVER(a_done_and_error, clk_i, rst_ni, out_valid_o && frame_done_o && frame_error_o)
  // A completed frame always leaves the ready flag set.
  `CRF_ASSERT(a_done_sets_ready, clk_i, rst_ni, (out_valid_o && frame_done_o) |-> message_ready_o)
  // A new request is never taken over a result that is still held.
  `CRF_ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni, accept && out_valid_q && out_stall_i)
  // A request outside receive mode never touches the error count.
  `CRF_ASSERT(a_idle_keeps_errors, clk_i, rst_ni,
              (accept && (mode_i != crf_pkg::MODE_RECV)) |=> (error_count_o == $past(u_parser.errors_q)))

endmodule
